FILE: sv/bfgr_pkg.sv
// Shared types, constants and helper functions of the bitmap font glyph renderer.
// Depends on nothing; every other file of the block imports it.
package bfgr_pkg;

	// default sizes of the glyph store
	localparam int MAX_GLYPHS_DEF     = 256;
	localparam int ROWS_PER_GLYPH_DEF = 16;

	// drawing bounds and framebuffer geometry
	localparam int MAX_WIDTH       = 8;
	localparam int MAX_HEIGHT      = 16;
	localparam int BYTES_PER_PIXEL = 4;

	// field widths
	localparam int CODE_W   = 16;
	localparam int RIDX_W   = 4;
	localparam int BITS_W   = 8;
	localparam int POS_W    = 12;
	localparam int COLOR_W  = 32;
	localparam int ADDR_OUT_W = 32;
	localparam int MASK_W   = 9;
	localparam int COUNT_W  = 9;
	localparam int HEIGHT_W = 5;
	localparam int WIDTH_W  = 4;
	localparam int PITCH_W  = 16;
	localparam int MODE_W   = 2;
	localparam int ROW_W    = 5;

	// shared multiply-add operand widths
	localparam int MAC_A_W = 20;
	localparam int MAC_B_W = 16;

	// stream beat layout
	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 120;
	localparam int IN_CODE_LSB = 0;
	localparam int IN_RIDX_LSB = 16;
	localparam int IN_BITS_LSB = 20;
	localparam int IN_PX_LSB   = 28;
	localparam int IN_PY_LSB   = 40;
	localparam int IN_FG_LSB   = 52;
	localparam int IN_BG_LSB   = 84;
	localparam int IN_USED_W   = 116;
	localparam int OUT_USED_W  = 114;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd256;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 5'd16;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 4'd8;
	localparam logic [PITCH_W-1:0]  PITCH_RST  = 16'd4096;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLYPH_COUNT  = 2'd0,
		REG_GLYPH_HEIGHT = 2'd1,
		REG_GLYPH_WIDTH  = 2'd2,
		REG_LINE_PITCH   = 2'd3
	} reg_idx_t;

	// item kinds carried in tuser
	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_OPAQUE = 2'd1,
		MODE_TRANSP = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// register file contents handed to the sequencer
	typedef struct packed {
		logic [COUNT_W-1:0]  glyph_count;
		logic [HEIGHT_W-1:0] glyph_height;
		logic [WIDTH_W-1:0]  glyph_width;
		logic [PITCH_W-1:0]  line_pitch;
	} cfg_t;

	// foreground mask: bit k is pixel k from the left, msb of the row byte first
	function automatic logic [MASK_W-1:0] pixel_mask(input logic [BITS_W-1:0] bits,
			input logic [WIDTH_W-1:0] w);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int k = 0; k < MAX_WIDTH; k++) begin
			m[k] = bits[MAX_WIDTH-1-k] && (WIDTH_W'(k) < w);
		end
		return m;
	endfunction

	// all w+1 pixels of a row
	function automatic logic [MASK_W-1:0] full_mask(input logic [WIDTH_W-1:0] w);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int k = 0; k < MASK_W; k++) begin
			m[k] = (WIDTH_W'(k) <= w);
		end
		return m;
	endfunction

endpackage

FILE: sv/bfgr_cfg_regs.sv
// Configuration register file of the glyph renderer.
// Depends on bfgr_pkg for the register indexes, reset values and cfg_t.
module bfgr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bfgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bfgr_pkg::CFG_DATA_W-1:0] cfg_data,
	output bfgr_pkg::cfg_t                cfg
);
	import bfgr_pkg::*;

	cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_count  <= COUNT_RST;
			cfg_q.glyph_height <= HEIGHT_RST;
			cfg_q.glyph_width  <= WIDTH_RST;
			cfg_q.line_pitch   <= PITCH_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GLYPH_COUNT:  cfg_q.glyph_count  <= cfg_data[COUNT_W-1:0];
				REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data[HEIGHT_W-1:0];
				REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data[WIDTH_W-1:0];
				REG_LINE_PITCH:   cfg_q.line_pitch   <= cfg_data[PITCH_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

FILE: sv/bfgr_glyph_store.sv
// Glyph bitmap store: one row byte per entry, one write and one registered read port.
// Depends on bfgr_pkg for the row byte width.
module bfgr_glyph_store #(
	parameter int DEPTH  = bfgr_pkg::MAX_GLYPHS_DEF * bfgr_pkg::ROWS_PER_GLYPH_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [bfgr_pkg::BITS_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [bfgr_pkg::BITS_W-1:0] rd_data
);
	import bfgr_pkg::*;

	logic [BITS_W-1:0] mem_q [DEPTH];
	logic [BITS_W-1:0] rd_data_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/bfgr_mac_unit.sv
// Shared multiply-add unit: addend + a * b, wrapping at 32 bits.
// Depends on bfgr_pkg for the operand widths.
module bfgr_mac_unit (
	input  logic [bfgr_pkg::MAC_A_W-1:0]    a,
	input  logic [bfgr_pkg::MAC_B_W-1:0]    b,
	input  logic [bfgr_pkg::ADDR_OUT_W-1:0] addend,
	output logic [bfgr_pkg::ADDR_OUT_W-1:0] sum
);
	import bfgr_pkg::*;

	logic [MAC_A_W+MAC_B_W-1:0] product;

	// one multiply, one add, result kept modulo 2^32
	assign product = MAC_A_W'(a) * MAC_B_W'(b);
	assign sum     = addend + product[ADDR_OUT_W-1:0];

endmodule

FILE: sv/bitmap_font_glyph_renderer.sv
// Top level of the bitmap font glyph renderer: stream ports, sequencer, output register.
// Depends on bfgr_pkg, bfgr_cfg_regs, bfgr_glyph_store and bfgr_mac_unit.
//
// A load beat (tuser 0) writes one glyph row byte; a tuser 3 beat is dropped. A draw
// beat (tuser 1 opaque at a character cell, tuser 2 transparent at a pixel) computes
// its framebuffer base address on one shared multiply-add unit, in ST_MUL1, ST_MUL2
// and ST_MUL3 for opaque and in ST_MUL1 and ST_MUL2 for transparent, then gives one
// output beat per glyph row, one row per cycle from the store's read port unless the
// output side stalls; a draw with a glyph height of zero gives no beat. s_axis_tready
// is low while a draw runs. The last row's beat may still wait in the output register
// while the next beat is taken. The glyph store needs no clearing after reset: a glyph
// must be loaded before it is drawn.
module bitmap_font_glyph_renderer #(
	parameter int MAX_GLYPHS     = bfgr_pkg::MAX_GLYPHS_DEF,
	parameter int ROWS_PER_GLYPH = bfgr_pkg::ROWS_PER_GLYPH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bfgr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bfgr_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input beats
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// char_code, row_index, row_bits, pos_x, pos_y, fg_color, bg_color, zero fill
	input  logic [bfgr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// mode
	input  logic [bfgr_pkg::MODE_W-1:0]       s_axis_tuser,
	// output beats
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// row_address, fg_mask, write_mask, out_fg, out_bg, zero fill
	output logic [bfgr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// last_row
	output logic                              m_axis_tlast
);
	import bfgr_pkg::*;

	localparam int DEPTH   = MAX_GLYPHS * ROWS_PER_GLYPH;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GLYPH_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_ROWS
	} state_t;

	cfg_t cfg;

	// input beat fields
	mode_t              in_mode;
	logic [CODE_W-1:0]  in_code;
	logic [RIDX_W-1:0]  in_ridx;
	logic [BITS_W-1:0]  in_bits;
	logic [POS_W-1:0]   in_px;
	logic [POS_W-1:0]   in_py;
	logic [COLOR_W-1:0] in_fg;
	logic [COLOR_W-1:0] in_bg;

	// sequencer state and latched draw parameters
	state_t              state_q;
	logic                opaque_q;
	logic [WIDTH_W-1:0]  w_q;
	logic [ROW_W-1:0]    h_q;
	logic [ROW_W-1:0]    y_q;
	logic [POS_W-1:0]    px_q;
	logic [POS_W-1:0]    py_q;
	logic [COLOR_W-1:0]  fg_q;
	logic [COLOR_W-1:0]  bg_q;
	logic [ADDR_W-1:0]   gbase_q;
	logic [ADDR_OUT_W-1:0] acc_q;
	logic                row_ok_q;

	// output register
	logic                  out_valid_q;
	logic [ADDR_OUT_W-1:0] out_addr_q;
	logic [MASK_W-1:0]     out_fm_q;
	logic [MASK_W-1:0]     out_wm_q;
	logic [COLOR_W-1:0]    out_fg_q;
	logic [COLOR_W-1:0]    out_bg_q;
	logic                  out_last_q;

	// combinational helpers
	logic                  in_fire;
	logic                  is_draw;
	logic [WIDTH_W-1:0]    w_sat;
	logic [ROW_W-1:0]      h_sat;
	logic                  code_valid;
	logic [GLYPH_W-1:0]    glyph_sel;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  rd_en;
	logic [ROW_W-1:0]      rd_row;
	logic [ADDR_W-1:0]     rd_addr;
	logic [BITS_W-1:0]     rd_data;
	logic                  emit;
	logic                  last;
	logic [BITS_W-1:0]     row_bits;
	logic [MASK_W-1:0]     fm;
	logic [MAC_A_W-1:0]    mac_a;
	logic [MAC_B_W-1:0]    mac_b;
	logic [ADDR_OUT_W-1:0] mac_add;
	logic [ADDR_OUT_W-1:0] mac_sum;

	bfgr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// unpack the input beat
	assign in_mode = mode_t'(s_axis_tuser);
	assign in_code = s_axis_tdata[IN_CODE_LSB +: CODE_W];
	assign in_ridx = s_axis_tdata[IN_RIDX_LSB +: RIDX_W];
	assign in_bits = s_axis_tdata[IN_BITS_LSB +: BITS_W];
	assign in_px   = s_axis_tdata[IN_PX_LSB +: POS_W];
	assign in_py   = s_axis_tdata[IN_PY_LSB +: POS_W];
	assign in_fg   = s_axis_tdata[IN_FG_LSB +: COLOR_W];
	assign in_bg   = s_axis_tdata[IN_BG_LSB +: COLOR_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign is_draw       = (in_mode == MODE_OPAQUE) || (in_mode == MODE_TRANSP);

	// saturated width and height
	assign w_sat = (cfg.glyph_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
	                                                         : cfg.glyph_width;
	assign h_sat = (cfg.glyph_height > HEIGHT_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT)
	                                                            : ROW_W'(cfg.glyph_height);

	// fallback to glyph zero for codes outside the font
	assign code_valid = (in_code != '0)
	                 && (in_code < CODE_W'(cfg.glyph_count))
	                 && ({1'b0, in_code} < (CODE_W+1)'(MAX_GLYPHS));
	assign glyph_sel  = code_valid ? in_code[GLYPH_W-1:0] : '0;

	// glyph row load
	assign wr_en   = in_fire && (in_mode == MODE_LOAD)
	              && ({1'b0, in_code} < (CODE_W+1)'(MAX_GLYPHS))
	              && (int'(in_ridx) < ROWS_PER_GLYPH);
	assign wr_addr = ADDR_W'(in_code[GLYPH_W-1:0] * ROWS_PER_GLYPH)
	               + ADDR_W'(in_ridx);

	// row fetch: row zero during the first setup step, the next row on each emitted beat
	assign emit    = (state_q == ST_ROWS) && (!out_valid_q || m_axis_tready);
	assign last    = (y_q == h_q - ROW_W'(1));
	assign rd_row  = (state_q == ST_ROWS) ? (y_q + ROW_W'(1)) : '0;
	assign rd_en   = (state_q == ST_MUL1) || (emit && !last);
	assign rd_addr = gbase_q + ADDR_W'(rd_row);

	bfgr_glyph_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (in_bits),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// rows past the glyph's bitmap are background
	assign row_bits = row_ok_q ? rd_data : '0;
	assign fm       = pixel_mask(row_bits, w_q);

	// operand selection for the shared multiply-add
	always_comb begin
		mac_a   = '0;
		mac_b   = '0;
		mac_add = '0;
		unique case (state_q)
			ST_MUL1: begin
				mac_a = MAC_A_W'(py_q);
				mac_b = opaque_q ? MAC_B_W'(h_q) : cfg.line_pitch;
			end
			ST_MUL2: begin
				if (opaque_q) begin
					mac_a = acc_q[MAC_A_W-1:0];
					mac_b = cfg.line_pitch;
				end else begin
					mac_a   = MAC_A_W'(px_q);
					mac_b   = MAC_B_W'(BYTES_PER_PIXEL);
					mac_add = acc_q;
				end
			end
			ST_MUL3: begin
				mac_a   = MAC_A_W'(px_q);
				mac_b   = MAC_B_W'(w_q + WIDTH_W'(1)) * MAC_B_W'(BYTES_PER_PIXEL);
				mac_add = acc_q;
			end
			ST_ROWS: begin
				mac_a   = MAC_A_W'(cfg.line_pitch);
				mac_b   = MAC_B_W'(1);
				mac_add = acc_q;
			end
			default: begin
				mac_a   = '0;
				mac_b   = '0;
				mac_add = '0;
			end
		endcase
	end

	bfgr_mac_unit u_mac (
		.a      (mac_a),
		.b      (mac_b),
		.addend (mac_add),
		.sum    (mac_sum)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set by an emitted row, cleared once the beat is taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && is_draw && (h_sat != '0)) begin
						state_q  <= ST_MUL1;
						opaque_q <= (in_mode == MODE_OPAQUE);
						w_q      <= w_sat;
						h_q      <= h_sat;
						y_q      <= '0;
						px_q     <= in_px;
						py_q     <= in_py;
						fg_q     <= in_fg;
						bg_q     <= (in_mode == MODE_OPAQUE) ? in_bg : '0;
						gbase_q  <= ADDR_W'(glyph_sel * ROWS_PER_GLYPH);
					end
				end
				ST_MUL1: begin
					acc_q    <= mac_sum;
					row_ok_q <= ((ROW_W+1)'(rd_row) < (ROW_W+1)'(ROWS_PER_GLYPH));
					state_q  <= ST_MUL2;
				end
				ST_MUL2: begin
					acc_q   <= mac_sum;
					state_q <= opaque_q ? ST_MUL3 : ST_ROWS;
				end
				ST_MUL3: begin
					acc_q   <= mac_sum;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (emit) begin
						out_addr_q  <= acc_q;
						out_fm_q    <= fm;
						out_wm_q    <= opaque_q ? full_mask(w_q) : fm;
						out_fg_q    <= fg_q;
						out_bg_q    <= bg_q;
						out_last_q  <= last;
						acc_q       <= mac_sum;
						y_q         <= y_q + ROW_W'(1);
						row_ok_q    <= ((ROW_W+1)'(rd_row) < (ROW_W+1)'(ROWS_PER_GLYPH));
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pack the output beat
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {(OUT_TDATA_W-OUT_USED_W)'(0), out_bg_q, out_fg_q,
	                        out_wm_q, out_fm_q, out_addr_q};

endmodule

FILE: sv/bfgr_checker.sv
// Port-level checks of the glyph renderer, attached to the top level by bind.
// Depends on bfgr_pkg for the item kinds; sees only the top level's ports.
module bfgr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_ready,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [bfgr_pkg::MODE_W-1:0]      s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [bfgr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tlast
);
	import bfgr_pkg::*;

	// a stalled output beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// loads and unused kinds never hold off the next beat
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready
			&& (s_axis_tuser == MODE_LOAD || s_axis_tuser == MODE_NONE)
		|=> s_axis_tready)
		else $error("input not ready after a load or unused beat");

	// no output beat once reset has been seen
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

	// configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind bitmap_font_glyph_renderer bfgr_checker u_bfgr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_ready     (cfg_ready),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: tb/sv/bitmap_font_glyph_renderer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_font_glyph_renderer: glyph loads, opaque and transparent
// draws, register settings, random stalls on both streams. Depends on bfgr_pkg and the RTL.
module bitmap_font_glyph_renderer_tb;
	import bfgr_pkg::*;

	localparam int unsigned RUN_LIMIT   = 1000000;
	localparam int unsigned IDLE_CYCLES = 24;
	localparam int unsigned GLYPH_ROWS  = ROWS_PER_GLYPH_DEF;

	// one drawn glyph row as it should leave the block
	typedef struct {
		bit [31:0] addr;
		bit [8:0]  fg_mask;
		bit [8:0]  wr_mask;
		bit [31:0] fg;
		bit [31:0] bg;
		bit        is_last;
	} row_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [MODE_W-1:0]      s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	// shadow of the registers and of the glyph store
	bit [8:0]  font_count = COUNT_RST;
	bit [4:0]  font_height = HEIGHT_RST;
	bit [3:0]  font_width = WIDTH_RST;
	bit [15:0] font_pitch = PITCH_RST;
	bit [7:0]  glyph_rows [0:MAX_GLYPHS_DEF*ROWS_PER_GLYPH_DEF-1];
	bit        row_written [0:MAX_GLYPHS_DEF*ROWS_PER_GLYPH_DEF-1];
	bit        glyph_full [0:MAX_GLYPHS_DEF-1];
	bit [15:0] full_glyphs [$];

	row_beat_t   row_beats_due [$];
	row_beat_t   due_beat;
	int unsigned fail_count = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	bit          tx_offering = 1'b0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	int unsigned rx_hold_req = 0;
	int unsigned rx_hold_left = 0;
	int unsigned rx_stall_left = 0;

	bitmap_font_glyph_renderer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("%0t: run limit reached", $time);
			$display("status: fail");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// positions near the edges come up often
	function automatic bit [11:0] pick_pos();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 12'd0;
		if (r == 1)
			return 12'hFFF;
		return 12'($urandom);
	endfunction

	// a draw may only read store rows that were written
	function automatic bit glyph_readable(bit [15:0] code);
		int unsigned g, rows, y;
		g = (code > 0 && code < font_count && code < MAX_GLYPHS_DEF) ? code : 0;
		rows = (font_height > MAX_HEIGHT) ? MAX_HEIGHT : font_height;
		for (y = 0; y < rows; y++) begin
			if (!row_written[g*GLYPH_ROWS + y])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit [15:0] pick_draw_code();
		bit [15:0] c;
		if (full_glyphs.size() > 0 && $urandom_range(0, 3) != 0)
			c = full_glyphs[$urandom_range(0, full_glyphs.size() - 1)];
		else
			c = 16'($urandom);
		if (!glyph_readable(c))
			c = 16'd0;
		return c;
	endfunction

	// store update for a load, row beats for a draw
	task automatic compute_row_beats(mode_t md, bit [15:0] code, bit [3:0] ridx,
			bit [7:0] bits, bit [11:0] px, bit [11:0] py, bit [31:0] fg, bit [31:0] bg);
		bit [31:0] w, h, g, base, pitch, full;
		bit [8:0] fm;
		bit [7:0] rowb;
		bit all_rows;
		row_beat_t b;
		int unsigned y, k;
		case (md)
			MODE_LOAD: begin
				if (code < MAX_GLYPHS_DEF) begin
					glyph_rows[code*GLYPH_ROWS + ridx] = bits;
					row_written[code*GLYPH_ROWS + ridx] = 1'b1;
					all_rows = 1'b1;
					for (y = 0; y < GLYPH_ROWS; y++)
						all_rows &= row_written[code*GLYPH_ROWS + y];
					if (all_rows && !glyph_full[code]) begin
						glyph_full[code] = 1'b1;
						full_glyphs.push_back(code);
					end
				end
			end
			MODE_OPAQUE, MODE_TRANSP: begin
				w = (font_width > MAX_WIDTH) ? MAX_WIDTH : font_width;
				h = (font_height > MAX_HEIGHT) ? MAX_HEIGHT : font_height;
				g = (code > 0 && code < font_count && code < MAX_GLYPHS_DEF) ? code : 0;
				pitch = font_pitch;
				full = (32'd1 << (w + 1)) - 1;
				if (md == MODE_OPAQUE)
					base = 32'(py) * h * pitch + 32'(px) * (w + 1) * BYTES_PER_PIXEL;
				else
					base = 32'(px) * BYTES_PER_PIXEL + 32'(py) * pitch;
				for (y = 0; y < h; y++) begin
					rowb = (y < GLYPH_ROWS) ? glyph_rows[g*GLYPH_ROWS + y] : 8'd0;
					fm = '0;
					for (k = 0; k < w; k++)
						fm[k] = rowb[7 - k];
					b.addr = base + y * pitch;
					b.fg_mask = fm;
					b.wr_mask = (md == MODE_OPAQUE) ? full[8:0] : fm;
					b.fg = fg;
					b.bg = (md == MODE_OPAQUE) ? bg : 32'd0;
					b.is_last = (y + 1 == h);
					row_beats_due.push_back(b);
				end
			end
			default: ;
		endcase
	endtask

	// offer one input beat and wait for it to be taken
	task automatic send_item(mode_t md, bit [15:0] code, bit [3:0] ridx, bit [7:0] bits,
			bit [11:0] px, bit [11:0] py, bit [31:0] fg, bit [31:0] bg);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= md;
		s_axis_tdata <= {4'd0, bg, fg, py, px, bits, ridx, code};
		tx_offering = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (md != MODE_NONE && !(md == MODE_LOAD && code >= MAX_GLYPHS_DEF))
			items_sent++;
		compute_row_beats(md, code, ridx, bits, px, py, fg, bg);
		gap = tx_idle_en ? gap_cycles() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			tx_offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_row(bit [15:0] code, bit [3:0] ridx, bit [7:0] bits);
		send_item(MODE_LOAD, code, ridx, bits, 12'($urandom), 12'($urandom), $urandom,
			$urandom);
	endtask

	// random mode, position and colors; unreadable glyphs fall back to code zero
	task automatic draw_glyph(bit [15:0] code);
		bit [11:0] px, py;
		if (!glyph_readable(code))
			code = 16'd0;
		px = pick_pos();
		py = pick_pos();
		send_item($urandom_range(0, 1) ? MODE_OPAQUE : MODE_TRANSP, code, 4'($urandom),
			8'($urandom), px, py, $urandom, $urandom);
	endtask

	// stop offering and wait for every predicted row
	task automatic wait_drain();
		if (tx_offering) begin
			s_axis_tvalid <= 1'b0;
			tx_offering = 1'b0;
		end
		do
			@(posedge clk);
		while (row_beats_due.size() != 0);
	endtask

	// one register beat, valid left high for the next one
	task automatic put_reg(reg_idx_t idx, bit [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// write all registers once the block is idle
	task automatic apply_settings(bit [8:0] cnt, bit [4:0] hgt, bit [3:0] wid, bit [15:0] pitch);
		wait_drain();
		repeat (IDLE_CYCLES) @(posedge clk);
		put_reg(REG_GLYPH_COUNT, 16'(cnt));
		put_reg(REG_GLYPH_HEIGHT, 16'(hgt));
		put_reg(REG_GLYPH_WIDTH, 16'(wid));
		put_reg(REG_LINE_PITCH, pitch);
		cfg_valid <= 1'b0;
		font_count = cnt;
		font_height = hgt;
		font_width = wid;
		font_pitch = pitch;
	endtask

	// glyph zero, ignored items, field extremes and fallback codes at reset settings
	task automatic test_directed();
		bit [7:0] pat [16] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
			8'hC3, 8'h3C, 8'h81, 8'h7E, 8'h18, 8'hE7, 8'h24, 8'hDB};
		int unsigned r;
		for (r = 0; r < GLYPH_ROWS; r++)
			load_row(16'd0, 4'(r), pat[r]);
		// loads past the store are dropped
		load_row(16'hFFFF, 4'hF, 8'hFF);
		load_row(16'd256, 4'd0, 8'hFF);
		// unused mode
		send_item(MODE_NONE, 16'hFFFF, 4'hF, 8'hFF, 12'hFFF, 12'hFFF, '1, '1);
		send_item(MODE_OPAQUE, 16'd0, 4'd0, 8'd0, 12'd0, 12'd0, 32'd0, '1);
		send_item(MODE_OPAQUE, 16'd0, 4'hF, 8'hFF, 12'hFFF, 12'hFFF, '1, 32'd0);
		send_item(MODE_TRANSP, 16'd0, 4'd0, 8'd0, 12'hFFF, 12'hFFF, '1, '1);
		send_item(MODE_TRANSP, 16'd0, 4'hF, 8'hFF, 12'd0, 12'd0, 32'h5A5A_A5A5, '1);
		// codes at or beyond the glyph count
		send_item(MODE_OPAQUE, 16'd256, 4'd0, 8'd0, 12'd1, 12'd1, 32'h1234_5678, '1);
		send_item(MODE_TRANSP, 16'hFFFF, 4'd0, 8'd0, 12'd7, 12'd3, '1, '1);
	endtask

	// register extremes, zero height and width, saturating height and width
	task automatic test_register_extremes();
		bit [8:0]  cnts [6] = '{9'd1, 9'd256, 9'd128, 9'd256, 9'd256, 9'd17};
		bit [4:0]  hgts [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd16, 5'd20};
		bit [3:0]  wids [6] = '{4'd1, 4'd8, 4'd4, 4'd15, 4'd0, 4'd9};
		bit [15:0] pits [6] = '{16'd4, 16'd65535, 16'd1000, 16'd65535, 16'd4, 16'd12345};
		int unsigned i;
		for (i = 0; i < 6; i++) begin
			apply_settings(cnts[i], hgts[i], wids[i], pits[i]);
			draw_glyph(16'd1);
			draw_glyph(16'd200);
			draw_glyph(pick_draw_code());
		end
	endtask

	// glyph load then draw sequences, row edits, draw bursts and some noise
	task automatic test_random_traffic(int unsigned target);
		int unsigned start, kind, r;
		bit [15:0] g;
		bit [8:0] c;
		bit [4:0] h;
		bit [3:0] w;
		bit [15:0] p;
		start = items_sent;
		while (items_sent - start < target) begin
			if ($urandom_range(0, 5) == 0) begin
				c = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(1, 256));
				h = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(1, 16)) :
					5'($urandom_range(0, 31));
				w = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, 8)) :
					4'($urandom_range(0, 15));
				case ($urandom_range(0, 3))
					0: p = 16'd4;
					1: p = 16'd65535;
					default: p = 16'($urandom_range(4, 65535));
				endcase
				apply_settings(c, h, w, p);
			end
			tx_idle_en = ($urandom_range(0, 4) != 0);
			rx_idle_en = ($urandom_range(0, 4) != 0);
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				// fresh glyph
				g = 16'($urandom_range(1, MAX_GLYPHS_DEF - 1));
				for (r = 0; r < GLYPH_ROWS; r++)
					load_row(g, 4'(r), 8'($urandom));
				repeat ($urandom_range(2, 4)) draw_glyph(g);
			end else if (kind < 7) begin
				// rewrite rows of a loaded glyph
				g = full_glyphs[$urandom_range(0, full_glyphs.size() - 1)];
				repeat ($urandom_range(1, 4)) load_row(g, 4'($urandom), 8'($urandom));
				repeat ($urandom_range(2, 4)) draw_glyph(g);
			end else if (kind < 9) begin
				repeat ($urandom_range(3, 6)) draw_glyph(pick_draw_code());
			end else begin
				repeat ($urandom_range(2, 5)) begin
					case ($urandom_range(0, 3))
						0: send_item(MODE_NONE, 16'($urandom), 4'($urandom), 8'($urandom),
							12'($urandom), 12'($urandom), $urandom, $urandom);
						1: load_row(16'($urandom_range(MAX_GLYPHS_DEF, 65535)), 4'($urandom),
							8'($urandom));
						2: load_row(16'($urandom_range(1, MAX_GLYPHS_DEF - 1)), 4'($urandom),
							8'($urandom));
						default: draw_glyph(16'($urandom));
					endcase
				end
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// output held off for a long stretch while tall glyphs keep coming
	task automatic test_output_hold();
		apply_settings(9'd256, 5'd16, 4'd8, 16'd4096);
		tx_idle_en = 1'b0;
		rx_hold_req = 300;
		repeat (12) draw_glyph(pick_draw_code());
		tx_idle_en = 1'b1;
	endtask

	// sender waits for every row before the next burst
	task automatic test_drain_pause();
		repeat (3) begin
			repeat (3) draw_glyph(pick_draw_code());
			wait_drain();
		end
	endtask

	// output ready: random stalls plus an occasional long hold
	always @(posedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left = rx_hold_left - 1;
		end else if (rx_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left = rx_stall_left - 1;
		end else begin
			rx_stall_left = rx_idle_en ? gap_cycles() : 0;
			m_axis_tready <= (rx_stall_left == 0);
		end
	end

	task automatic cmp_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
		if (exp_v != act_v) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// compare each output beat with the oldest predicted row
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (row_beats_due.size() == 0) begin
				$display("%0t ns: unexpected row beat, expected none, actual %h", $time,
					m_axis_tdata);
				fail_count++;
			end else begin
				due_beat = row_beats_due.pop_front();
				cmp_field("row_address", due_beat.addr, m_axis_tdata[31:0]);
				cmp_field("fg_mask", 32'(due_beat.fg_mask), 32'(m_axis_tdata[40:32]));
				cmp_field("write_mask", 32'(due_beat.wr_mask), 32'(m_axis_tdata[49:41]));
				cmp_field("out_fg", due_beat.fg, m_axis_tdata[81:50]);
				cmp_field("out_bg", due_beat.bg, m_axis_tdata[113:82]);
				cmp_field("last_row", 32'(due_beat.is_last), 32'(m_axis_tlast));
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_traffic(300);
		test_output_hold();
		test_drain_pause();
		wait_drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: files.f
sv/bfgr_pkg.sv
sv/bfgr_cfg_regs.sv
sv/bfgr_glyph_store.sv
sv/bfgr_mac_unit.sv
sv/bitmap_font_glyph_renderer.sv
sv/bfgr_checker.sv
tb/sv/bitmap_font_glyph_renderer_tb.sv
